>>> hdl/spfd_pkg.sv
// ----------------------------------------------------------------------------
// spfd_pkg
// Shared types and constants for the sensor pulse frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package spfd_pkg;

  // Field widths.
  localparam int DUR_W    = 16;
  localparam int WORD_W   = 16;
  localparam int CSUM_W   = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 6;
  localparam int INDEX_W  = 2;

  // Frame layout: data pulses after the lead, and where each field starts.
  localparam int DATA_PULSES = 40;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 6'd63;
  localparam logic [COUNT_W-1:0] TEMP_START = 6'd16;
  localparam logic [COUNT_W-1:0] CSUM_START = 6'd32;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LENGTH      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HUMIDITY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TEMPERATURE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CHECKSUM    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_MISMATCH    = 3'd5;

  // Configuration register indexes.
  localparam logic [INDEX_W-1:0] REG_ONE_LOW   = 2'd0;
  localparam logic [INDEX_W-1:0] REG_ONE_HIGH  = 2'd1;
  localparam logic [INDEX_W-1:0] REG_ZERO_LOW  = 2'd2;
  localparam logic [INDEX_W-1:0] REG_ZERO_HIGH = 2'd3;

  // Reset values of the window registers.
  localparam logic [DUR_W-1:0] ONE_LOW_RST   = 16'd110;
  localparam logic [DUR_W-1:0] ONE_HIGH_RST  = 16'd140;
  localparam logic [DUR_W-1:0] ZERO_LOW_RST  = 16'd70;
  localparam logic [DUR_W-1:0] ZERO_HIGH_RST = 16'd100;

  // Decode windows handed to the pulse classifier.
  typedef struct packed {
    logic [DUR_W-1:0] one_low;
    logic [DUR_W-1:0] one_high;
    logic [DUR_W-1:0] zero_low;
    logic [DUR_W-1:0] zero_high;
  } windows_t;

  // Outcome of classifying one pulse.
  typedef struct packed {
    logic good;
    logic bit_value;
  } pulse_class_t;

endpackage

`default_nettype wire

>>> hdl/spfd_pulse_class.sv
// ----------------------------------------------------------------------------
// spfd_pulse_class
// Sorts one pulse duration into a one bit, a zero bit or a bad pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module spfd_pulse_class (
  input  wire logic [spfd_pkg::DUR_W-1:0] duration,
  input  wire spfd_pkg::windows_t         windows,
  output spfd_pkg::pulse_class_t          result
);

  logic in_one;
  logic in_zero;

  // Both windows are open on each side; the one window wins when they overlap.
  assign in_one  = (duration > windows.one_low) && (duration < windows.one_high);
  assign in_zero = (duration > windows.zero_low) && (duration < windows.zero_high);

  assign result.good      = in_one || in_zero;
  assign result.bit_value = in_one;

endmodule

`default_nettype wire

>>> hdl/sensor_pulse_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// sensor_pulse_frame_decoder_top
// Decodes a frame of pulse durations into humidity and temperature words.
// ----------------------------------------------------------------------------
// The block takes one pulse duration per cycle while in_stall is low, with no
// gaps needed. An accepted word is captured in an input register, then
// classified against the windows and shifted into the frame state; for the
// word marked frame_end the status and both words are loaded into the result
// register instead, with out_valid, when that word leaves the input register.
// The first LEAD_PULSES pulses of a frame are skipped and the following 40 are
// decoded MSB first. Input stalls only while a finished result waits in the
// result register and the next frame end needs it. Window registers are
// written through the cfg port, which is always ready; the user must write
// them only while the block is idle, as the block does not enforce this.
`default_nettype none

module sensor_pulse_frame_decoder_top #(
  parameter int LEAD_PULSES = 3
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Pulse input channel.
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [spfd_pkg::DUR_W-1:0]        pulse_duration,
  input  wire logic                              frame_end,
  // Result channel.
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [spfd_pkg::STATUS_W-1:0]          status,
  output logic [spfd_pkg::WORD_W-1:0]            humidity_word,
  output logic [spfd_pkg::WORD_W-1:0]            temperature_word,
  // Configuration write channel.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [spfd_pkg::INDEX_W-1:0]      cfg_index,
  input  wire logic [spfd_pkg::DUR_W-1:0]        cfg_data
);

  localparam logic [spfd_pkg::COUNT_W-1:0] LEAD_CNT =
    spfd_pkg::COUNT_W'(LEAD_PULSES);
  localparam logic [spfd_pkg::COUNT_W-1:0] FRAME_CNT =
    spfd_pkg::COUNT_W'(LEAD_PULSES + spfd_pkg::DATA_PULSES);

  // Window registers.
  spfd_pkg::windows_t windows;

  // Input register.
  logic                         in_full;
  logic [spfd_pkg::DUR_W-1:0]   in_duration;
  logic                         in_last;

  // Frame state.
  logic [spfd_pkg::COUNT_W-1:0]  pulse_count;
  logic [spfd_pkg::WORD_W-1:0]   humidity_shift;
  logic [spfd_pkg::WORD_W-1:0]   temperature_shift;
  logic [spfd_pkg::CSUM_W-1:0]   checksum_shift;
  logic [spfd_pkg::STATUS_W-1:0] first_error;

  logic [spfd_pkg::COUNT_W-1:0]  pulse_count_next;
  logic [spfd_pkg::WORD_W-1:0]   humidity_shift_next;
  logic [spfd_pkg::WORD_W-1:0]   temperature_shift_next;
  logic [spfd_pkg::CSUM_W-1:0]   checksum_shift_next;
  logic [spfd_pkg::STATUS_W-1:0] first_error_next;
  logic [spfd_pkg::STATUS_W-1:0] status_next;

  spfd_pkg::pulse_class_t        pclass;
  logic [spfd_pkg::COUNT_W-1:0]  data_pos;
  logic [spfd_pkg::STATUS_W-1:0] field_code;
  logic                          is_data;
  logic [spfd_pkg::CSUM_W-1:0]   byte_sum;

  logic out_free;
  logic in_move;
  logic take;

  // Handshake: the input register drains unless a frame end meets a full result.
  assign out_free  = !out_valid || !out_stall;
  assign in_move   = !in_full || !in_last || out_free;
  assign take      = in_full && in_move;
  assign in_stall  = !in_move;
  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      windows.one_low   <= spfd_pkg::ONE_LOW_RST;
      windows.one_high  <= spfd_pkg::ONE_HIGH_RST;
      windows.zero_low  <= spfd_pkg::ZERO_LOW_RST;
      windows.zero_high <= spfd_pkg::ZERO_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        spfd_pkg::REG_ONE_LOW:   windows.one_low   <= cfg_data;
        spfd_pkg::REG_ONE_HIGH:  windows.one_high  <= cfg_data;
        spfd_pkg::REG_ZERO_LOW:  windows.zero_low  <= cfg_data;
        spfd_pkg::REG_ZERO_HIGH: windows.zero_high <= cfg_data;
        default:                 windows.one_low   <= windows.one_low;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_move) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_move && in_valid) begin
      in_duration <= pulse_duration;
      in_last     <= frame_end;
    end
  end

  spfd_pulse_class u_pulse_class (
    .duration (in_duration),
    .windows  (windows),
    .result   (pclass)
  );

  // Position of the pulse within the data section and the field it feeds.
  assign is_data  = (pulse_count >= LEAD_CNT) && (pulse_count < FRAME_CNT);
  assign data_pos = pulse_count - LEAD_CNT;

  always_comb begin
    priority if (data_pos < spfd_pkg::TEMP_START) begin
      field_code = spfd_pkg::ST_HUMIDITY;
    end else if (data_pos < spfd_pkg::CSUM_START) begin
      field_code = spfd_pkg::ST_TEMPERATURE;
    end else begin
      field_code = spfd_pkg::ST_CHECKSUM;
    end
  end

  // Frame state update for the pulse in the input register.
  always_comb begin
    humidity_shift_next    = humidity_shift;
    temperature_shift_next = temperature_shift;
    checksum_shift_next    = checksum_shift;
    first_error_next       = first_error;
    if (is_data) begin
      if (!pclass.good) begin
        if (first_error == spfd_pkg::ST_OK) begin
          first_error_next = field_code;
        end
      end else begin
        unique case (field_code)
          spfd_pkg::ST_HUMIDITY:
            humidity_shift_next = {humidity_shift[spfd_pkg::WORD_W-2:0], pclass.bit_value};
          spfd_pkg::ST_TEMPERATURE:
            temperature_shift_next =
              {temperature_shift[spfd_pkg::WORD_W-2:0], pclass.bit_value};
          default:
            checksum_shift_next = {checksum_shift[spfd_pkg::CSUM_W-2:0], pclass.bit_value};
        endcase
      end
    end
    pulse_count_next = (pulse_count < spfd_pkg::COUNT_MAX) ?
                       pulse_count + 6'd1 : pulse_count;
  end

  // Byte sum of the four data bytes, kept to eight bits.
  assign byte_sum = humidity_shift_next[15:8] + humidity_shift_next[7:0]
                  + temperature_shift_next[15:8] + temperature_shift_next[7:0];

  // Status in order of priority: length, first bad field, checksum.
  always_comb begin
    priority if (pulse_count_next != FRAME_CNT) begin
      status_next = spfd_pkg::ST_LENGTH;
    end else if (first_error_next != spfd_pkg::ST_OK) begin
      status_next = first_error_next;
    end else if (byte_sum != checksum_shift_next) begin
      status_next = spfd_pkg::ST_MISMATCH;
    end else begin
      status_next = spfd_pkg::ST_OK;
    end
  end

  // Frame state registers; a frame end returns them to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_count       <= '0;
      humidity_shift    <= '0;
      temperature_shift <= '0;
      checksum_shift    <= '0;
      first_error       <= spfd_pkg::ST_OK;
    end else if (take) begin
      if (in_last) begin
        pulse_count       <= '0;
        humidity_shift    <= '0;
        temperature_shift <= '0;
        checksum_shift    <= '0;
        first_error       <= spfd_pkg::ST_OK;
      end else begin
        pulse_count       <= pulse_count_next;
        humidity_shift    <= humidity_shift_next;
        temperature_shift <= temperature_shift_next;
        checksum_shift    <= checksum_shift_next;
        first_error       <= first_error_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && in_last) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_last) begin
      status <= status_next;
      if (status_next == spfd_pkg::ST_OK) begin
        humidity_word    <= humidity_shift_next;
        temperature_word <= temperature_shift_next;
      end else begin
        humidity_word    <= '0;
        temperature_word <= '0;
      end
    end
  end

endmodule

`default_nettype wire
